// File: rtl/core/h264_flv_tag_framer_top_assert.svh
// Assertion macros for the FLV tag framer checker.
// Used by h264ff_checker; expects clk_i and rst_ni in scope.
`ifndef H264_FLV_TAG_FRAMER_TOP_ASSERT_SVH
`define H264_FLV_TAG_FRAMER_TOP_ASSERT_SVH

// same-cycle implication
`define H264FF_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define H264FF_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/core/h264ff_pkg.sv
// Shared types and constants of the FLV tag framer.
// No dependencies.
package h264ff_pkg;

  // input kind codes
  localparam logic [1:0] KIND_VIDEO   = 2'd0;
  localparam logic [1:0] KIND_AUD_SEQ = 2'd1;

  // output packet kind codes
  localparam logic [1:0] PK_SEQ   = 2'd0;
  localparam logic [1:0] PK_VIDEO = 2'd1;
  localparam logic [1:0] PK_AUDIO = 2'd2;

  // byte values
  localparam logic [7:0] NAL_SPS        = 8'h67;
  localparam logic [7:0] NAL_PPS        = 8'h68;
  localparam logic [7:0] NAL_IDR        = 8'h65;
  localparam logic [7:0] BYTE_AVC_KEY   = 8'h17;
  localparam logic [7:0] BYTE_AVC_INTER = 8'h27;
  localparam logic [7:0] BYTE_RSV_FF    = 8'hFF;
  localparam logic [7:0] BYTE_NUM_SPS   = 8'hE1;
  localparam logic [7:0] BYTE_AAC       = 8'hAF;
  localparam logic [7:0] BYTE_ONE       = 8'h01;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [31:0] START_CODE    = 32'h0000_0001;

  // what the emitter has to send for one accepted word
  typedef enum logic [1:0] {
    JOB_DATA,
    JOB_AUDHDR,
    JOB_VIDHDR
  } job_e;

  typedef struct packed {
    logic        vld;
    job_e        jtype;
    logic [1:0]  pkind;
    logic [7:0]  data;
    logic        last;
    logic [31:0] stamp;
    logic        aud_raw;
    logic        key;
    logic        with_seq;
    logic [31:0] flen;
  } job_t;

endpackage

// File: rtl/core/h264ff_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module h264ff_ram #(
  parameter int W = 8,
  parameter int D = 8
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/h264ff_parse.sv
// Buffer parser: tracks position and mode, captures SPS/PPS into the set RAMs,
// and hands at most one emit job per accepted word. Depends on h264ff_pkg.
module h264ff_parse #(
  parameter int SPS_MAX = 24,
  parameter int PPS_MAX = 8,
  localparam int SAW = $clog2(SPS_MAX),
  localparam int PAW = $clog2(PPS_MAX),
  localparam int SCW = $clog2(SPS_MAX + 1),
  localparam int PCW = $clog2(PPS_MAX + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_acc_i,
  input  logic [1:0]         kind_i,
  input  logic [7:0]         data_byte_i,
  input  logic [23:0]        total_len_i,
  input  logic [31:0]        timestamp_i,
  output h264ff_pkg::job_t   job_o,
  output logic               sps_we_o,
  output logic [SAW-1:0]     sps_waddr_o,
  output logic               pps_we_o,
  output logic [PAW-1:0]     pps_waddr_o,
  output logic [SCW-1:0]     sps_cnt_o,
  output logic [PCW-1:0]     pps_cnt_o
);

  typedef enum logic [1:0] {
    MODE_VHDR,
    MODE_VDATA,
    MODE_AUDIO,
    MODE_PSET
  } mode_e;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_PPS,
    PH_SKIP
  } phase_e;

  logic [23:0]    pos_q, pos_d;
  logic [31:0]    recent_q, recent_d;
  mode_e          mode_q, mode_d, mode_cur;
  phase_e         phase_q, phase_d;
  logic [SCW-1:0] sps_cnt_q, sps_cnt_d;
  logic [PCW-1:0] pps_cnt_q, pps_cnt_d;
  logic           valid_q, valid_d;

  logic           p_zero, last;
  logic [23:0]    rel4, rel8, q_pps, q_new;

  assign p_zero = (pos_q == 24'd0);
  assign last   = (({1'b0, pos_q} + 25'd1) >= {1'b0, total_len_i});
  assign rel4   = pos_q - 24'd4;
  assign rel8   = pos_q - 24'd8;
  assign q_pps  = pos_q - (24'(sps_cnt_q) + 24'd8);

  // next state and job decode
  always_comb begin
    pos_d       = pos_q;
    recent_d    = recent_q;
    mode_d      = mode_q;
    phase_d     = phase_q;
    sps_cnt_d   = sps_cnt_q;
    pps_cnt_d   = pps_cnt_q;
    valid_d     = valid_q;
    q_new       = '0;
    sps_we_o    = 1'b0;
    sps_waddr_o = '0;
    pps_we_o    = 1'b0;
    pps_waddr_o = '0;
    mode_cur    = p_zero ? ((kind_i == h264ff_pkg::KIND_VIDEO) ? MODE_VHDR : MODE_AUDIO)
                         : mode_q;

    job_o          = '0;
    job_o.jtype    = h264ff_pkg::JOB_DATA;
    job_o.pkind    = h264ff_pkg::PK_VIDEO;
    job_o.data     = data_byte_i;
    job_o.last     = last;
    job_o.stamp    = timestamp_i;
    job_o.aud_raw  = (kind_i != h264ff_pkg::KIND_AUD_SEQ);
    job_o.key      = (data_byte_i == h264ff_pkg::NAL_IDR);
    job_o.with_seq = (data_byte_i == h264ff_pkg::NAL_IDR) && valid_q;
    job_o.flen     = {8'd0, total_len_i} - 32'd4;

    if (in_acc_i) begin
      mode_d = mode_cur;
      case (mode_cur)
        MODE_AUDIO: begin
          job_o.vld   = 1'b1;
          job_o.jtype = p_zero ? h264ff_pkg::JOB_AUDHDR : h264ff_pkg::JOB_DATA;
          job_o.pkind = h264ff_pkg::PK_AUDIO;
        end
        MODE_VDATA: begin
          job_o.vld = 1'b1;
        end
        MODE_VHDR: begin
          if (pos_q == 24'd4) begin
            if (data_byte_i == h264ff_pkg::NAL_SPS) begin
              mode_d = MODE_PSET;
              if (valid_q) begin
                phase_d = PH_SKIP;
              end else begin
                phase_d  = PH_SEEK;
                sps_we_o = 1'b1;
              end
            end else begin
              mode_d      = MODE_VDATA;
              job_o.vld   = 1'b1;
              job_o.jtype = h264ff_pkg::JOB_VIDHDR;
            end
          end
        end
        default: begin
          // parameter-set buffer
          case (phase_q)
            PH_SEEK: begin
              if (pos_q >= 24'd9 && recent_q == h264ff_pkg::START_CODE &&
                  data_byte_i == h264ff_pkg::NAL_PPS) begin
                if (rel8 > 24'(SPS_MAX)) begin
                  phase_d = PH_SKIP;
                end else begin
                  sps_cnt_d = rel8[SCW-1:0];
                  phase_d   = PH_PPS;
                  pps_we_o  = 1'b1;
                end
              end else if (pos_q >= 24'd4 && rel4 < 24'(SPS_MAX)) begin
                sps_we_o    = 1'b1;
                sps_waddr_o = rel4[SAW-1:0];
              end
            end
            PH_PPS: begin
              if (q_pps < 24'(PPS_MAX)) begin
                pps_we_o    = 1'b1;
                pps_waddr_o = q_pps[PAW-1:0];
              end else begin
                phase_d = PH_SKIP;
              end
            end
            default: ;
          endcase
          // buffer ends while collecting the PPS: both sets are in
          if (last && phase_d == PH_PPS) begin
            q_new     = pos_q - (24'(sps_cnt_d) + 24'd8);
            pps_cnt_d = q_new[PCW-1:0] + PCW'(1);
            valid_d   = 1'b1;
          end
        end
      endcase
      recent_d = {recent_q[23:0], data_byte_i};
      pos_d    = last ? 24'd0 : (pos_q + 24'd1);
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= 24'd0;
      recent_q  <= '1;
      mode_q    <= MODE_VHDR;
      phase_q   <= PH_SEEK;
      sps_cnt_q <= '0;
      pps_cnt_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      recent_q  <= recent_d;
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      sps_cnt_q <= sps_cnt_d;
      pps_cnt_q <= pps_cnt_d;
      valid_q   <= valid_d;
    end
  end

  assign sps_cnt_o = sps_cnt_q;
  assign pps_cnt_o = pps_cnt_q;

endmodule

// File: rtl/core/h264ff_emit.sv
// Emit sequencer: turns jobs into output words, reading the set RAMs for the
// AVC sequence header, and holds the output register. Depends on h264ff_pkg.
module h264ff_emit #(
  parameter int SPS_MAX = 24,
  parameter int PPS_MAX = 8,
  localparam int SAW = $clog2(SPS_MAX),
  localparam int PAW = $clog2(PPS_MAX),
  localparam int SCW = $clog2(SPS_MAX + 1),
  localparam int PCW = $clog2(PPS_MAX + 1),
  localparam int IW  = $clog2(SPS_MAX + PPS_MAX + 16)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  h264ff_pkg::job_t job_i,
  output logic             ready_o,
  input  logic [SCW-1:0]   sps_cnt_i,
  input  logic [PCW-1:0]   pps_cnt_i,
  output logic             sps_re_o,
  output logic [SAW-1:0]   sps_raddr_o,
  input  logic [7:0]       sps_rdata_i,
  output logic             pps_re_o,
  output logic [PAW-1:0]   pps_raddr_o,
  input  logic [7:0]       pps_rdata_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       out_kind_o,
  output logic             out_end_o,
  output logic [31:0]      out_stamp_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SH_HEAD,
    ST_SH_PROF,
    ST_SH_MID,
    ST_SH_SPS,
    ST_SH_PMID,
    ST_SH_PPS,
    ST_VHDR,
    ST_AHDR,
    ST_DATA
  } state_e;

  state_e      st_q, first_st;
  logic [IW-1:0] idx_q;
  logic        pend_q;
  logic        ovld_q, oend_q;
  logic [7:0]  obyte_q;
  logic [1:0]  opk_q;
  logic [31:0] ostamp_q;

  // captured job
  logic [7:0]  data_q;
  logic        last_q, aud_raw_q, key_q;
  logic [1:0]  pkind_q;
  logic [31:0] stamp_q, flen_q;

  logic        slot_free, fetch_st, seq_st, step;
  logic [7:0]  w_byte;
  logic        w_end;
  logic [15:0] sl16, pl16;
  logic        sps_last, pps_last;

  assign slot_free = !ovld_q || out_ready_i;
  assign fetch_st  = (st_q == ST_SH_PROF) || (st_q == ST_SH_SPS) || (st_q == ST_SH_PPS);
  assign seq_st    = (st_q == ST_SH_HEAD) || (st_q == ST_SH_PROF) || (st_q == ST_SH_MID) ||
                     (st_q == ST_SH_SPS) || (st_q == ST_SH_PMID) || (st_q == ST_SH_PPS);
  assign step      = (st_q != ST_IDLE) && slot_free && (!fetch_st || pend_q);
  assign ready_o   = (st_q == ST_IDLE) || ((st_q == ST_DATA) && slot_free);

  assign sl16     = 16'(sps_cnt_i);
  assign pl16     = 16'(pps_cnt_i);
  assign sps_last = ((idx_q + IW'(1)) == IW'(sps_cnt_i));
  assign pps_last = ((idx_q + IW'(1)) == IW'(pps_cnt_i));

  // memory reads: issued ahead of the word that uses them
  assign sps_re_o    = !pend_q && ((st_q == ST_SH_PROF) || (st_q == ST_SH_SPS));
  assign sps_raddr_o = idx_q[SAW-1:0];
  assign pps_re_o    = !pend_q && (st_q == ST_SH_PPS);
  assign pps_raddr_o = idx_q[PAW-1:0];

  // first state of a new job
  always_comb begin
    case (job_i.jtype)
      h264ff_pkg::JOB_AUDHDR: first_st = ST_AHDR;
      h264ff_pkg::JOB_VIDHDR: first_st = job_i.with_seq ? ST_SH_HEAD : ST_VHDR;
      default:                first_st = ST_DATA;
    endcase
  end

  // word byte and end flag for the current step
  always_comb begin
    w_end = 1'b0;
    case (st_q)
      ST_SH_HEAD: begin
        if (idx_q == IW'(0))      w_byte = h264ff_pkg::BYTE_AVC_KEY;
        else if (idx_q == IW'(5)) w_byte = h264ff_pkg::BYTE_ONE;
        else                      w_byte = h264ff_pkg::BYTE_ZERO;
      end
      ST_SH_PROF, ST_SH_SPS: w_byte = sps_rdata_i;
      ST_SH_MID: begin
        case (idx_q)
          IW'(0):  w_byte = h264ff_pkg::BYTE_RSV_FF;
          IW'(1):  w_byte = h264ff_pkg::BYTE_NUM_SPS;
          IW'(2):  w_byte = sl16[15:8];
          default: w_byte = sl16[7:0];
        endcase
      end
      ST_SH_PMID: begin
        case (idx_q)
          IW'(0):  w_byte = h264ff_pkg::BYTE_ONE;
          IW'(1):  w_byte = pl16[15:8];
          default: begin
            w_byte = pl16[7:0];
            w_end  = (pps_cnt_i == '0);
          end
        endcase
      end
      ST_SH_PPS: begin
        w_byte = pps_rdata_i;
        w_end  = pps_last;
      end
      ST_VHDR: begin
        case (idx_q)
          IW'(0):  w_byte = key_q ? h264ff_pkg::BYTE_AVC_KEY : h264ff_pkg::BYTE_AVC_INTER;
          IW'(1):  w_byte = h264ff_pkg::BYTE_ONE;
          IW'(5):  w_byte = flen_q[31:24];
          IW'(6):  w_byte = flen_q[23:16];
          IW'(7):  w_byte = flen_q[15:8];
          IW'(8):  w_byte = flen_q[7:0];
          default: w_byte = h264ff_pkg::BYTE_ZERO;
        endcase
      end
      ST_AHDR: begin
        if (idx_q == IW'(0)) w_byte = h264ff_pkg::BYTE_AAC;
        else w_byte = aud_raw_q ? h264ff_pkg::BYTE_ONE : h264ff_pkg::BYTE_ZERO;
      end
      ST_DATA: begin
        w_byte = data_q;
        w_end  = last_q;
      end
      default: w_byte = h264ff_pkg::BYTE_ZERO;
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      idx_q     <= '0;
      pend_q    <= 1'b0;
      ovld_q    <= 1'b0;
      obyte_q   <= '0;
      opk_q     <= '0;
      oend_q    <= 1'b0;
      ostamp_q  <= '0;
      data_q    <= '0;
      last_q    <= 1'b0;
      aud_raw_q <= 1'b0;
      key_q     <= 1'b0;
      pkind_q   <= '0;
      stamp_q   <= '0;
      flen_q    <= '0;
    end else begin
      if (ovld_q && out_ready_i) begin
        ovld_q <= 1'b0;
      end
      if (fetch_st && !pend_q) begin
        pend_q <= 1'b1;
      end
      if (step) begin
        ovld_q   <= 1'b1;
        obyte_q  <= w_byte;
        oend_q   <= w_end;
        opk_q    <= seq_st ? h264ff_pkg::PK_SEQ : pkind_q;
        ostamp_q <= seq_st ? 32'd0 : stamp_q;
        pend_q   <= 1'b0;
        idx_q    <= idx_q + IW'(1);
        case (st_q)
          ST_SH_HEAD: begin
            if (idx_q == IW'(5)) begin
              st_q  <= ST_SH_PROF;
              idx_q <= IW'(1);
            end
          end
          ST_SH_PROF: begin
            if (idx_q == IW'(3)) begin
              st_q  <= ST_SH_MID;
              idx_q <= '0;
            end
          end
          ST_SH_MID: begin
            if (idx_q == IW'(3)) begin
              st_q  <= (sps_cnt_i == '0) ? ST_SH_PMID : ST_SH_SPS;
              idx_q <= '0;
            end
          end
          ST_SH_SPS: begin
            if (sps_last) begin
              st_q  <= ST_SH_PMID;
              idx_q <= '0;
            end
          end
          ST_SH_PMID: begin
            if (idx_q == IW'(2)) begin
              st_q  <= (pps_cnt_i == '0) ? ST_VHDR : ST_SH_PPS;
              idx_q <= '0;
            end
          end
          ST_SH_PPS: begin
            if (pps_last) begin
              st_q  <= ST_VHDR;
              idx_q <= '0;
            end
          end
          ST_VHDR: begin
            if (idx_q == IW'(8)) begin
              st_q  <= ST_DATA;
              idx_q <= '0;
            end
          end
          ST_AHDR: begin
            if (idx_q == IW'(1)) begin
              st_q  <= ST_DATA;
              idx_q <= '0;
            end
          end
          default: begin
            st_q  <= ST_IDLE;
            idx_q <= '0;
          end
        endcase
      end
      // a new job only arrives while ready_o is high
      if (job_i.vld) begin
        st_q      <= first_st;
        idx_q     <= '0;
        data_q    <= job_i.data;
        last_q    <= job_i.last;
        aud_raw_q <= job_i.aud_raw;
        key_q     <= job_i.key;
        pkind_q   <= job_i.pkind;
        stamp_q   <= job_i.stamp;
        flen_q    <= job_i.flen;
      end
    end
  end

  assign out_valid_o = ovld_q;
  assign out_byte_o  = obyte_q;
  assign out_kind_o  = opk_q;
  assign out_end_o   = oend_q;
  assign out_stamp_o = ostamp_q;

endmodule

// File: rtl/core/h264_flv_tag_framer_top.sv
// Top level of the FLV tag framer: parser, emit sequencer and SPS/PPS RAMs.
// Depends on h264ff_pkg, h264ff_ram, h264ff_parse, h264ff_emit.
//
// channel  dir  tdata (low bit up)                          tuser        tlast
// s_axis   in   data_byte[7:0] total_len[31:8] timestamp    kind[1:0]    -
// m_axis   out  out_byte[7:0] stamp_out[39:8]               packet_kind  packet_end
//
// Payload words of audio and video take one cycle each; the fifth byte of a
// video buffer issues 10 words, an audio buffer's first byte 3.
// A keyframe's sequence header adds 16 + SPS + PPS words; each set byte is
// first read from its set RAM, then issued as a word. Input is held off
// while a header burst runs. Reset needs no clearing pass (the set RAMs are
// only read after they were written). A stalled m_axis holds its word.
module h264_flv_tag_framer_top #(
  parameter int SPS_MAX = 24,
  parameter int PPS_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // data_byte, total_len, timestamp
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // out_byte, stamp_out
  output logic [1:0]  m_axis_tuser,   // packet_kind
  output logic        m_axis_tlast
);

  localparam int SAW = $clog2(SPS_MAX);
  localparam int PAW = $clog2(PPS_MAX);
  localparam int SCW = $clog2(SPS_MAX + 1);
  localparam int PCW = $clog2(PPS_MAX + 1);

  h264ff_pkg::job_t job;
  logic             in_acc;
  logic             sps_we, pps_we, sps_re, pps_re;
  logic [SAW-1:0]   sps_waddr, sps_raddr;
  logic [PAW-1:0]   pps_waddr, pps_raddr;
  logic [7:0]       sps_rdata, pps_rdata, out_byte;
  logic [SCW-1:0]   sps_cnt;
  logic [PCW-1:0]   pps_cnt;
  logic [31:0]      out_stamp;

  assign in_acc = s_axis_tvalid && s_axis_tready;

  h264ff_parse #(
    .SPS_MAX (SPS_MAX),
    .PPS_MAX (PPS_MAX)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_acc_i    (in_acc),
    .kind_i      (s_axis_tuser),
    .data_byte_i (s_axis_tdata[7:0]),
    .total_len_i (s_axis_tdata[31:8]),
    .timestamp_i (s_axis_tdata[63:32]),
    .job_o       (job),
    .sps_we_o    (sps_we),
    .sps_waddr_o (sps_waddr),
    .pps_we_o    (pps_we),
    .pps_waddr_o (pps_waddr),
    .sps_cnt_o   (sps_cnt),
    .pps_cnt_o   (pps_cnt)
  );

  // SPS store
  h264ff_ram #(
    .W (8),
    .D (SPS_MAX)
  ) u_sps_ram (
    .clk_i   (clk_i),
    .we_i    (sps_we),
    .waddr_i (sps_waddr),
    .wdata_i (s_axis_tdata[7:0]),
    .re_i    (sps_re),
    .raddr_i (sps_raddr),
    .rdata_o (sps_rdata)
  );

  // PPS store
  h264ff_ram #(
    .W (8),
    .D (PPS_MAX)
  ) u_pps_ram (
    .clk_i   (clk_i),
    .we_i    (pps_we),
    .waddr_i (pps_waddr),
    .wdata_i (s_axis_tdata[7:0]),
    .re_i    (pps_re),
    .raddr_i (pps_raddr),
    .rdata_o (pps_rdata)
  );

  h264ff_emit #(
    .SPS_MAX (SPS_MAX),
    .PPS_MAX (PPS_MAX)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .ready_o     (s_axis_tready),
    .sps_cnt_i   (sps_cnt),
    .pps_cnt_i   (pps_cnt),
    .sps_re_o    (sps_re),
    .sps_raddr_o (sps_raddr),
    .sps_rdata_i (sps_rdata),
    .pps_re_o    (pps_re),
    .pps_raddr_o (pps_raddr),
    .pps_rdata_i (pps_rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (out_byte),
    .out_kind_o  (m_axis_tuser),
    .out_end_o   (m_axis_tlast),
    .out_stamp_o (out_stamp)
  );

  assign m_axis_tdata = {out_stamp, out_byte};

endmodule

// File: rtl/core/h264ff_checker.sv
// Port-level checker for the FLV tag framer, bound to the top level.
// Depends on h264ff_pkg and h264_flv_tag_framer_top_assert.svh.
`include "h264_flv_tag_framer_top_assert.svh"

module h264ff_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled word holds
  `H264FF_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output word changed under stall")

  // sequence header words carry a zero stamp
  `H264FF_ASSERT_IMP(a_seq_stamp, m_axis_tvalid && m_axis_tuser == h264ff_pkg::PK_SEQ, m_axis_tdata[39:8] == 32'd0, "sequence header word with nonzero stamp")

  // sequence header is followed at once by the keyframe tag header
  `H264FF_ASSERT_NXT(a_seq_then_key, m_axis_tvalid && m_axis_tready && m_axis_tlast && m_axis_tuser == h264ff_pkg::PK_SEQ, m_axis_tvalid && m_axis_tuser == h264ff_pkg::PK_VIDEO && m_axis_tdata[7:0] == h264ff_pkg::BYTE_AVC_KEY, "sequence header not followed by keyframe tag")

  // no input taken while a header burst is on the output
  `H264FF_ASSERT_IMP(a_seq_no_input, m_axis_tvalid && m_axis_tuser == h264ff_pkg::PK_SEQ, !s_axis_tready, "input ready during sequence header")

endmodule

bind h264_flv_tag_framer_top h264ff_checker u_checker (.*);

// File: tb/sv/flv_tag_monitor.sv
`timescale 1ns / 100ps
// Scoreboard for the FLV tag framer: models the framer from the accepted input words
// and compares each output word with the oldest predicted one. Depends on h264ff_pkg.
module flv_tag_monitor #(
  parameter int SPS_MAX = 24,
  parameter int PPS_MAX = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // data_byte, total_len, timestamp
  input  logic [1:0]  s_axis_tuser,   // kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,   // out_byte, stamp_out
  input  logic [1:0]  m_axis_tuser,   // packet_kind
  input  logic        m_axis_tlast,   // packet_end
  output int          fail_count_o,
  output int          pending_words_o
);

  localparam int SAW = $clog2(SPS_MAX);
  localparam int PAW = $clog2(PPS_MAX);

  typedef enum logic [1:0] {
    BUF_HDR,
    BUF_FRAME,
    BUF_AUDIO,
    BUF_SETS
  } buf_mode_e;

  typedef enum logic [1:0] {
    CAP_SEEK,
    CAP_PPS,
    CAP_SKIP
  } cap_phase_e;

  typedef struct packed {
    logic [7:0]  body;
    logic [1:0]  pkind;
    logic        eop;
    logic [31:0] stamp;
  } tag_word_t;

  // framer model state
  logic [23:0] byte_pos;
  logic [31:0] last_four;
  buf_mode_e   mode;
  cap_phase_e  phase;
  logic [7:0]  sps_mem [SPS_MAX];
  logic [7:0]  pps_mem [PPS_MAX];
  logic [31:0] sps_len;
  logic [31:0] pps_len;
  logic        sets_ok;

  tag_word_t   tag_words_q [$];
  tag_word_t   want_w;
  int          fails;

  task automatic push_word(input logic [7:0] body, input logic [1:0] pkind,
                           input logic eop, input logic [31:0] stamp);
    tag_words_q.push_back('{body, pkind, eop, stamp});
  endtask

  // AVC sequence header: tag header and decoder configuration record from the stored sets
  task automatic push_seq_header();
    logic [31:0] sl;
    logic [31:0] pl;
    sl = (sps_len > SPS_MAX) ? SPS_MAX : sps_len;
    pl = (pps_len > PPS_MAX) ? PPS_MAX : pps_len;
    push_word(h264ff_pkg::BYTE_AVC_KEY, h264ff_pkg::PK_SEQ, 1'b0, '0);
    repeat (4) push_word(h264ff_pkg::BYTE_ZERO, h264ff_pkg::PK_SEQ, 1'b0, '0);
    push_word(h264ff_pkg::BYTE_ONE, h264ff_pkg::PK_SEQ, 1'b0, '0);
    for (int i = 1; i <= 3; i++) push_word(sps_mem[SAW'(i)], h264ff_pkg::PK_SEQ, 1'b0, '0);
    push_word(h264ff_pkg::BYTE_RSV_FF, h264ff_pkg::PK_SEQ, 1'b0, '0);
    push_word(h264ff_pkg::BYTE_NUM_SPS, h264ff_pkg::PK_SEQ, 1'b0, '0);
    push_word(sl[15:8], h264ff_pkg::PK_SEQ, 1'b0, '0);
    push_word(sl[7:0], h264ff_pkg::PK_SEQ, 1'b0, '0);
    for (int i = 0; i < sl; i++) push_word(sps_mem[SAW'(i)], h264ff_pkg::PK_SEQ, 1'b0, '0);
    push_word(h264ff_pkg::BYTE_ONE, h264ff_pkg::PK_SEQ, 1'b0, '0);
    push_word(pl[15:8], h264ff_pkg::PK_SEQ, 1'b0, '0);
    push_word(pl[7:0], h264ff_pkg::PK_SEQ, pl == 0, '0);
    for (int i = 0; i < pl; i++)
      push_word(pps_mem[PAW'(i)], h264ff_pkg::PK_SEQ, i + 1 == pl, '0);
  endtask

  // one input byte through the framer model
  task automatic frame_byte(input logic [1:0] kind, input logic [7:0] b,
                            input logic [23:0] len, input logic [31:0] stamp);
    logic [31:0] p;
    logic [31:0] fl;
    logic [31:0] q;
    logic        last;
    p    = {8'd0, byte_pos};
    last = (p + 32'd1 >= {8'd0, len});
    // buffer kind is latched from its first byte
    if (p == 0) mode = (kind == h264ff_pkg::KIND_VIDEO) ? BUF_HDR : BUF_AUDIO;
    case (mode)
      BUF_AUDIO: begin
        if (p == 0) begin
          push_word(h264ff_pkg::BYTE_AAC, h264ff_pkg::PK_AUDIO, 1'b0, stamp);
          push_word((kind == h264ff_pkg::KIND_AUD_SEQ) ? h264ff_pkg::BYTE_ZERO
                                                       : h264ff_pkg::BYTE_ONE,
                    h264ff_pkg::PK_AUDIO, 1'b0, stamp);
        end
        push_word(b, h264ff_pkg::PK_AUDIO, last, stamp);
      end
      BUF_FRAME: push_word(b, h264ff_pkg::PK_VIDEO, last, stamp);
      BUF_HDR: begin
        // NAL header byte decides between a set buffer and a frame
        if (p == 4) begin
          if (b == h264ff_pkg::NAL_SPS) begin
            mode = BUF_SETS;
            if (sets_ok) begin
              phase = CAP_SKIP;
            end else begin
              phase = CAP_SEEK;
              sps_mem[SAW'(0)] = b;
            end
          end else begin
            fl   = {8'd0, len} - 32'd4;
            mode = BUF_FRAME;
            if (b == h264ff_pkg::NAL_IDR && sets_ok) push_seq_header();
            push_word((b == h264ff_pkg::NAL_IDR) ? h264ff_pkg::BYTE_AVC_KEY
                                                 : h264ff_pkg::BYTE_AVC_INTER,
                      h264ff_pkg::PK_VIDEO, 1'b0, stamp);
            push_word(h264ff_pkg::BYTE_ONE, h264ff_pkg::PK_VIDEO, 1'b0, stamp);
            repeat (3) push_word(h264ff_pkg::BYTE_ZERO, h264ff_pkg::PK_VIDEO, 1'b0, stamp);
            push_word(fl[31:24], h264ff_pkg::PK_VIDEO, 1'b0, stamp);
            push_word(fl[23:16], h264ff_pkg::PK_VIDEO, 1'b0, stamp);
            push_word(fl[15:8], h264ff_pkg::PK_VIDEO, 1'b0, stamp);
            push_word(fl[7:0], h264ff_pkg::PK_VIDEO, 1'b0, stamp);
            push_word(b, h264ff_pkg::PK_VIDEO, last, stamp);
          end
        end
      end
      default: begin
        // set capture: SPS up to the PPS start code, then PPS to buffer end
        if (phase == CAP_SEEK) begin
          if (p >= 9 && last_four == h264ff_pkg::START_CODE && b == h264ff_pkg::NAL_PPS) begin
            if (p - 32'd8 > SPS_MAX) begin
              phase = CAP_SKIP;
            end else begin
              sps_len          = p - 32'd8;
              phase            = CAP_PPS;
              pps_mem[PAW'(0)] = b;
            end
          end else if (p >= 4 && p - 32'd4 < SPS_MAX) begin
            sps_mem[SAW'(p - 32'd4)] = b;
          end
        end else if (phase == CAP_PPS) begin
          q = p - (sps_len + 32'd8);
          if (q < PPS_MAX) pps_mem[PAW'(q)] = b;
          else phase = CAP_SKIP;
        end
        if (last && phase == CAP_PPS) begin
          pps_len = p - (sps_len + 32'd8) + 32'd1;
          sets_ok = 1'b1;
        end
      end
    endcase
    last_four = {last_four[23:0], b};
    byte_pos  = last ? '0 : byte_pos + 24'd1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  // predict on input words, compare on output words
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos  = '0;
      last_four = '1;
      mode      = BUF_HDR;
      phase     = CAP_SEEK;
      sps_len   = '0;
      pps_len   = '0;
      sets_ok   = 1'b0;
      for (int i = 0; i < SPS_MAX; i++) sps_mem[SAW'(i)] = '0;
      for (int i = 0; i < PPS_MAX; i++) pps_mem[PAW'(i)] = '0;
      tag_words_q.delete();
      fails = 0;
      fail_count_o    <= 0;
      pending_words_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        frame_byte(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[31:8], s_axis_tdata[63:32]);
      if (m_axis_tvalid && m_axis_tready) begin
        if (tag_words_q.size() == 0) begin
          $error("out_byte: no word expected, got %0h", m_axis_tdata[7:0]);
          fails++;
        end else begin
          want_w = tag_words_q.pop_front();
          check_field("out_byte", 32'(want_w.body), 32'(m_axis_tdata[7:0]));
          check_field("packet_kind", 32'(want_w.pkind), 32'(m_axis_tuser));
          check_field("packet_end", 32'(want_w.eop), 32'(m_axis_tlast));
          check_field("stamp_out", want_w.stamp, m_axis_tdata[39:8]);
        end
      end
      fail_count_o    <= fails;
      pending_words_o <= tag_words_q.size();
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the FLV tag framer testbench: clock, reset, Annex-B buffer stimulus, output
// back-pressure and verdict. Depends on h264ff_pkg, h264_flv_tag_framer_top, flv_tag_monitor.
module tb;

  localparam int         SPS_MAX      = 24;
  localparam int         PPS_MAX      = 8;
  localparam logic [1:0] KIND_AUD_RAW = 2'd2;
  localparam logic [7:0] NAL_NON_IDR  = 8'h41;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // data_byte, total_len, timestamp
  logic [1:0]  s_axis_tuser;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // out_byte, stamp_out
  logic [1:0]  m_axis_tuser;   // packet_kind
  logic        m_axis_tlast;   // packet_end

  int          fail_count;
  int          pending_words;

  logic [7:0]  buf_q [$];
  bit          gaps_off;
  bit          kind_noise;
  int          words_taken;

  h264_flv_tag_framer_top #(
    .SPS_MAX(SPS_MAX),
    .PPS_MAX(PPS_MAX)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  flv_tag_monitor #(
    .SPS_MAX(SPS_MAX),
    .PPS_MAX(PPS_MAX)
  ) u_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .fail_count_o   (fail_count),
    .pending_words_o(pending_words)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog
  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  // offer one input word after a random gap (none while gaps_off) and wait for it to be taken
  task automatic put_byte(input logic [1:0] kind, input logic [7:0] b,
                          input logic [23:0] len, input logic [31:0] stamp);
    int gap;
    gap = gaps_off ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {stamp, len, b};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // send buf_q; claimed != 0 tags all but the last byte with that length
  // and ends the buffer on a shrunk length
  task automatic send_buffer(input logic [1:0] kind, input logic [31:0] stamp,
                             input logic [23:0] claimed);
    int          i;
    int          n;
    logic [1:0]  k;
    logic [23:0] len;
    n = buf_q.size();
    for (i = 0; i < n; i++) begin
      k = kind;
      if (i != 0 && kind_noise) k = 2'($urandom_range(0, 2));
      if (claimed == 0) len = 24'(n);
      else if (i == n - 1) len = 24'($urandom_range(1, i + 1));
      else len = claimed;
      put_byte(k, buf_q[i], len, stamp);
    end
  endtask

  task automatic rand_bytes(input int n);
    repeat (n) buf_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic start_nal(input logic [7:0] nal);
    buf_q.delete();
    repeat (3) buf_q.push_back(h264ff_pkg::BYTE_ZERO);
    buf_q.push_back(h264ff_pkg::BYTE_ONE);
    buf_q.push_back(nal);
  endtask

  // SPS of sps_n bytes, then a PPS of pps_n bytes (or a tail with no start code)
  task automatic build_sets(input int sps_n, input int pps_n, input bit with_pps);
    start_nal(h264ff_pkg::NAL_SPS);
    rand_bytes(sps_n - 1);
    if (with_pps) begin
      repeat (3) buf_q.push_back(h264ff_pkg::BYTE_ZERO);
      buf_q.push_back(h264ff_pkg::BYTE_ONE);
      buf_q.push_back(h264ff_pkg::NAL_PPS);
      rand_bytes(pps_n - 1);
    end else begin
      rand_bytes(pps_n);
    end
  endtask

  // output side: random stalls, quiet stretches and one long hold-off
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    words_taken = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (words_taken == 120) stall = 400;
      else if (words_taken % 64 < 16) stall = 0;
      else stall = $urandom_range(0, 13);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      words_taken++;
    end
  end

  // input side and verdict
  initial begin
    int          random_items;
    int          pick;
    logic [1:0]  kind;
    logic [7:0]  nal;
    logic [31:0] stamp;
    logic [23:0] claimed;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= h264ff_pkg::KIND_VIDEO;
    gaps_off      = 1'b0;
    kind_noise    = 1'b0;
    random_items  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // keyframe before any sets are stored: no sequence header
    start_nal(h264ff_pkg::NAL_IDR);
    send_buffer(h264ff_pkg::KIND_VIDEO, 32'h0, 24'd0);
    // video buffers that end before the NAL header
    for (int l = 1; l <= 4; l++) begin
      buf_q.delete();
      rand_bytes(l);
      send_buffer(h264ff_pkg::KIND_VIDEO, $urandom, 24'd0);
    end
    // set buffers that must not store: no PPS start code, SPS and PPS too long
    build_sets(6, 5, 1'b0);
    send_buffer(h264ff_pkg::KIND_VIDEO, $urandom, 24'd0);
    build_sets(SPS_MAX + 1, 2, 1'b1);
    send_buffer(h264ff_pkg::KIND_VIDEO, $urandom, 24'd0);
    build_sets(4, PPS_MAX + 1, 1'b1);
    send_buffer(h264ff_pkg::KIND_VIDEO, $urandom, 24'd0);
    // audio of both kinds; later bytes with a random kind
    buf_q.delete();
    buf_q.push_back(8'h00);
    send_buffer(h264ff_pkg::KIND_AUD_SEQ, 32'h0, 24'd0);
    buf_q.delete();
    buf_q.push_back(8'hFF);
    rand_bytes(2);
    kind_noise = 1'b1;
    send_buffer(KIND_AUD_RAW, 32'hFFFF_FFFF, 24'd0);
    kind_noise = 1'b0;
    // inter frame claiming the largest length, cut short by a shrunk length
    start_nal(NAL_NON_IDR);
    rand_bytes(3);
    send_buffer(h264ff_pkg::KIND_VIDEO, 32'hFFFF_FFFF, 24'hFF_FFFF);
    // half the runs store the largest sets here; in the rest, the random buffers may store sets later
    if ($urandom_range(0, 1) == 0) begin
      build_sets(SPS_MAX, PPS_MAX, 1'b1);
      send_buffer(h264ff_pkg::KIND_VIDEO, $urandom, 24'd0);
      start_nal(h264ff_pkg::NAL_IDR);
      rand_bytes(2);
      send_buffer(h264ff_pkg::KIND_VIDEO, $urandom, 24'd0);
      // sets already stored: ignored
      build_sets(5, 3, 1'b1);
      send_buffer(h264ff_pkg::KIND_VIDEO, $urandom, 24'd0);
    end

    // random buffers, at least 240 input words in all
    while (random_items < 240) begin
      gaps_off   = ($urandom_range(0, 7) == 0);
      kind_noise = ($urandom_range(0, 9) == 0);
      stamp      = $urandom;
      kind       = h264ff_pkg::KIND_VIDEO;
      pick       = $urandom_range(0, 9);
      case (pick)
        0, 1: begin
          build_sets(($urandom_range(0, 2) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(1, SPS_MAX + 2),
                     $urandom_range(1, PPS_MAX + 2), $urandom_range(0, 5) != 0);
        end
        2, 3, 4: begin
          start_nal(h264ff_pkg::NAL_IDR);
          rand_bytes($urandom_range(0, 12));
        end
        5, 6: begin
          nal = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 1) == 1) nal = NAL_NON_IDR;
          start_nal(nal);
          rand_bytes($urandom_range(0, 12));
        end
        7, 8: begin
          kind = 2'($urandom_range(1, 2));
          buf_q.delete();
          rand_bytes($urandom_range(1, 12));
        end
        default: begin
          kind = 2'($urandom_range(0, 2));
          buf_q.delete();
          rand_bytes($urandom_range(1, 10));
        end
      endcase
      claimed = 24'd0;
      if ($urandom_range(0, 9) == 0) claimed = 24'($urandom_range(buf_q.size(), 24'hFF_FFFF));
      send_buffer(kind, stamp, claimed);
      random_items += buf_q.size();
    end
    s_axis_tvalid <= 1'b0;

    // drain
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0 && pending_words == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: h264_flv_tag_framer_top.f
+incdir+rtl/core
rtl/core/h264ff_pkg.sv
rtl/core/h264ff_ram.sv
rtl/core/h264ff_parse.sv
rtl/core/h264ff_emit.sv
rtl/core/h264_flv_tag_framer_top.sv
rtl/core/h264ff_checker.sv
tb/sv/flv_tag_monitor.sv
tb/sv/tb.sv
